### src/rbba_pkg.sv
// ----------------------------------------------------------------------------
// Ring buffer block allocator package
// Shared widths, codes and the control bundle passed from the top level to
// each list cell.
// ----------------------------------------------------------------------------
package rbba_pkg;

    // Field and store widths fixed by the request and response formats.
    localparam int unsigned POS_W  = 13;
    localparam int unsigned LEN_W  = 13;
    localparam int unsigned OFF_W  = 12;
    localparam int unsigned CAP_W  = 13;
    localparam int unsigned LIVE_W = 5;

    // Register port geometry.
    localparam int unsigned APB_DW = 32;
    localparam int unsigned APB_AW = 3;

    // Register index, taken from the word address bit.
    localparam logic REG_CAPACITY = 1'b0;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [LEN_W-1:0] len_t;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_TRACKED   = 2'd0,
        KIND_UNTRACKED = 2'd1,
        KIND_FREE      = 2'd2,
        KIND_NONE      = 2'd3
    } kind_t;

    // Response status codes.
    typedef enum logic [2:0] {
        STAT_GRANTED    = 3'd0,
        STAT_BAD_LENGTH = 3'd1,
        STAT_NO_ROOM    = 3'd2,
        STAT_LIST_FULL  = 3'd3,
        STAT_FREED      = 3'd4,
        STAT_NOT_FOUND  = 3'd5
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_FIXUP = 2'd2
    } state_t;

    // Per-cell control bundle.
    typedef struct packed {
        logic load;      // write the new block into this cell
        logic shift_en;  // a free is executing this cycle
        logic valid;     // this cell holds a live block
    } cell_ctl_t;

endpackage

### src/ring_buffer_block_allocator.sv
// ----------------------------------------------------------------------------
// Ring buffer block allocator
// Hands out contiguous regions of a circular store and keeps an ordered list
// of live blocks in a row of cells.
// ----------------------------------------------------------------------------
// A request is first captured; then, in the execute step, every list cell
// compares its start with the request in parallel, the first match ripples
// along the cell row, the row closes the gap and the response is registered.
// A free that finds its block then takes a rebuild step, which reads the new
// last entry of the row to rebuild the end offset. The response waits in an
// output register until taken; a response that cannot leave holds the block
// in its execute or rebuild step. Writing the capacity register empties the
// store; the user must do so only while idle, as the block does not enforce it.
module ring_buffer_block_allocator #(
    parameter int unsigned STORE_BYTES = 4096,
    parameter int unsigned MAX_BLOCKS  = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rbba_pkg::APB_AW-1:0]       paddr,
    input  logic [rbba_pkg::APB_DW-1:0]       pwdata,
    output logic [rbba_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // Request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        kind,
    input  logic [rbba_pkg::LEN_W-1:0]        length,
    input  logic [rbba_pkg::OFF_W-1:0]        offset,
    // Response channel
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [2:0]                        status,
    output logic [rbba_pkg::OFF_W-1:0]        block_offset,
    output logic [rbba_pkg::LIVE_W-1:0]       live_blocks
);

    localparam int unsigned IDX_W     = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned CAP_MAX   = (1 << rbba_pkg::CAP_W) - 1;
    localparam int unsigned CAP_LIMIT = (STORE_BYTES > CAP_MAX) ? CAP_MAX : STORE_BYTES;
    localparam logic [rbba_pkg::CAP_W-1:0] CAP_LIM = rbba_pkg::CAP_W'(CAP_LIMIT);

    // Control state.
    rbba_pkg::state_t              state_reg;
    rbba_pkg::state_t              state_next;
    logic [rbba_pkg::CAP_W-1:0]    capacity_reg;
    logic [rbba_pkg::CAP_W-1:0]    capacity_next;
    rbba_pkg::pos_t                start_reg;
    rbba_pkg::pos_t                start_next;
    rbba_pkg::pos_t                end_reg;
    rbba_pkg::pos_t                end_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;

    // Captured request.
    rbba_pkg::kind_t               kind_reg;
    rbba_pkg::len_t                len_reg;
    logic [rbba_pkg::OFF_W-1:0]    off_reg;

    // Response payload.
    rbba_pkg::status_t             status_reg;
    rbba_pkg::status_t             status_next;
    logic [rbba_pkg::OFF_W-1:0]    boff_reg;
    logic [rbba_pkg::OFF_W-1:0]    boff_next;
    logic [rbba_pkg::LIVE_W-1:0]   live_reg;
    logic [rbba_pkg::LIVE_W-1:0]   live_next;

    // Handshake and sequencing.
    logic                          req_take;
    logic                          out_free;
    logic                          exec_go;
    logic                          fix_go;
    logic                          cap_wr;

    // Allocation arithmetic.
    logic [rbba_pkg::CAP_W-1:0]    cap_eff;
    rbba_pkg::pos_t                room_before;
    rbba_pkg::pos_t                room_after;
    rbba_pkg::pos_t                place_pos;
    rbba_pkg::pos_t                end_alloc;
    logic                          is_alloc;
    logic                          bad_len;
    logic                          list_full;
    logic                          fits;
    logic                          alloc_ok;
    logic                          free_ok;
    logic [IDX_W-1:0]              last_idx;

    // Cell row.
    rbba_pkg::cell_ctl_t           cell_ctl   [MAX_BLOCKS];
    rbba_pkg::pos_t                cell_start [MAX_BLOCKS];
    rbba_pkg::len_t                cell_len   [MAX_BLOCKS];
    logic [MAX_BLOCKS:0]           hit;
    rbba_pkg::pos_t                free_key;

    // Register port.
    assign pready = 1'b1;
    assign cap_wr = psel && penable && pwrite && pready && (paddr[2] == rbba_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == rbba_pkg::REG_CAPACITY)
                  ? {{(rbba_pkg::APB_DW - rbba_pkg::CAP_W){1'b0}}, capacity_reg}
                  : '0;

    // Effective capacity is bounded by the physical store.
    assign cap_eff = (capacity_reg > CAP_LIM) ? CAP_LIM : capacity_reg;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbba_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rbba_pkg::ST_EXEC;
                end
            end
            rbba_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = free_ok ? rbba_pkg::ST_FIXUP : rbba_pkg::ST_IDLE;
                end
            end
            rbba_pkg::ST_FIXUP:
            begin
                if (out_free)
                begin
                    state_next = rbba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbba_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        req_stall = 1'b1;
        exec_go   = 1'b0;
        fix_go    = 1'b0;
        case (state_reg)
            rbba_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            rbba_pkg::ST_EXEC:
            begin
                exec_go = out_free;
            end
            rbba_pkg::ST_FIXUP:
            begin
                fix_go = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign req_take = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Room after the end offset and before the start offset.
    always_comb
    begin
        if (start_reg <= end_reg)
        begin
            room_before = start_reg;
            room_after  = (end_reg <= cap_eff) ? (cap_eff - end_reg) : '0;
        end
        else
        begin
            room_before = '0;
            room_after  = start_reg - end_reg;
        end
    end

    // Placement and request checks.
    assign is_alloc  = (kind_reg == rbba_pkg::KIND_TRACKED) ||
                       (kind_reg == rbba_pkg::KIND_UNTRACKED);
    assign bad_len   = (cap_eff == '0) || (len_reg == '0) || (len_reg > cap_eff);
    assign list_full = (kind_reg == rbba_pkg::KIND_TRACKED) &&
                       (count_reg >= CNT_W'(MAX_BLOCKS));
    assign fits      = (room_after >= len_reg) || (len_reg <= room_before);
    assign place_pos = (room_after >= len_reg) ? end_reg : '0;
    assign end_alloc = place_pos + len_reg;
    assign alloc_ok  = is_alloc && !bad_len && !list_full && fits;
    assign free_ok   = (kind_reg == rbba_pkg::KIND_FREE) && (cap_eff != '0) && hit[MAX_BLOCKS];
    assign last_idx  = IDX_W'(count_reg - 1'b1);
    assign free_key  = {1'b0, off_reg};

    // Store and response updates.
    always_comb
    begin
        capacity_next  = capacity_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        boff_next      = boff_reg;
        live_next      = live_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (exec_go)
        begin
            if (is_alloc)
            begin
                rsp_valid_next = 1'b1;
                boff_next      = '0;
                if (bad_len)
                begin
                    status_next = rbba_pkg::STAT_BAD_LENGTH;
                end
                else if (list_full)
                begin
                    status_next = rbba_pkg::STAT_LIST_FULL;
                end
                else if (!fits)
                begin
                    status_next = rbba_pkg::STAT_NO_ROOM;
                end
                else
                begin
                    status_next = rbba_pkg::STAT_GRANTED;
                    boff_next   = place_pos[rbba_pkg::OFF_W-1:0];
                    end_next    = end_alloc;
                    if (kind_reg == rbba_pkg::KIND_UNTRACKED)
                    begin
                        start_next = place_pos;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                live_next = rbba_pkg::LIVE_W'(count_next);
            end
            else if (free_ok)
            begin
                // The response follows once the offsets are rebuilt.
                count_next = count_reg - 1'b1;
            end
            else
            begin
                rsp_valid_next = 1'b1;
                status_next    = rbba_pkg::STAT_NOT_FOUND;
                boff_next      = '0;
                live_next      = rbba_pkg::LIVE_W'(count_reg);
            end
        end

        // Rebuild start and end from the first and last live entries.
        if (fix_go)
        begin
            if (count_reg == '0)
            begin
                start_next = '0;
                end_next   = '0;
            end
            else
            begin
                start_next = cell_start[0];
                end_next   = cell_start[last_idx] + cell_len[last_idx];
            end
            rsp_valid_next = 1'b1;
            status_next    = rbba_pkg::STAT_FREED;
            boff_next      = '0;
            live_next      = rbba_pkg::LIVE_W'(count_reg);
        end

        // A capacity write starts a new, empty store.
        if (cap_wr)
        begin
            capacity_next = pwdata[rbba_pkg::CAP_W-1:0];
            start_next    = '0;
            end_next      = '0;
            count_next    = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbba_pkg::ST_IDLE;
            capacity_reg  <= rbba_pkg::CAP_RESET;
            start_reg     <= '0;
            end_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request capture and response payload.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            kind_reg <= rbba_pkg::kind_t'(kind);
            len_reg  <= length;
            off_reg  <= offset;
        end
        status_reg <= status_next;
        boff_reg   <= boff_next;
        live_reg   <= live_next;
    end

    // Row of list cells; the first-match flag ripples upwards.
    assign hit[0] = 1'b0;

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        rbba_pkg::pos_t nb_start;
        rbba_pkg::len_t nb_len;

        assign cell_ctl[g].load     = exec_go && alloc_ok &&
                                      (kind_reg == rbba_pkg::KIND_TRACKED) &&
                                      (count_reg == CNT_W'(g));
        assign cell_ctl[g].shift_en = exec_go && (kind_reg == rbba_pkg::KIND_FREE) &&
                                      (cap_eff != '0);
        assign cell_ctl[g].valid    = (CNT_W'(g) < count_reg);

        if (g == MAX_BLOCKS - 1)
        begin : g_top
            assign nb_start = cell_start[g];
            assign nb_len   = cell_len[g];
        end
        else
        begin : g_mid
            assign nb_start = cell_start[g+1];
            assign nb_len   = cell_len[g+1];
        end

        rbba_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[g]),
            .key       (free_key),
            .new_start (place_pos),
            .new_len   (len_reg),
            .nb_start  (nb_start),
            .nb_len    (nb_len),
            .hit_in    (hit[g]),
            .hit_out   (hit[g+1]),
            .start     (cell_start[g]),
            .len       (cell_len[g])
        );
    end

    // Response ports.
    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign block_offset = boff_reg;
    assign live_blocks  = live_reg;

    // The list never holds more blocks than there are cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count exceeds the cell row");

    // The end offset never runs past the usable store.
    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg <= cap_eff)
        else $error("end offset beyond capacity");

    // A response only appears out of the execute or rebuild step.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == rbba_pkg::ST_EXEC ||
                                  $past(state_reg) == rbba_pkg::ST_FIXUP))
        else $error("response raised outside an execute step");

    // Entering the rebuild step means exactly one block was removed.
    a_fixup_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rbba_pkg::ST_FIXUP && $past(state_reg) == rbba_pkg::ST_EXEC)
        |-> ($past(count_reg) == count_reg + 1'b1))
        else $error("rebuild step without a removed block");

endmodule

### src/rbba_cell.sv
// ----------------------------------------------------------------------------
// Block list cell
// Holds one live block (start and length). Compares its start with the free
// key, passes the first-match flag along the row and, at or above the first
// match, takes the entry of its upper neighbour to close the gap.
// ----------------------------------------------------------------------------
module rbba_cell
(
    input  logic                clk,
    input  rbba_pkg::cell_ctl_t ctl,
    input  rbba_pkg::pos_t      key,
    input  rbba_pkg::pos_t      new_start,
    input  rbba_pkg::len_t      new_len,
    input  rbba_pkg::pos_t      nb_start,
    input  rbba_pkg::len_t      nb_len,
    input  logic                hit_in,
    output logic                hit_out,
    output rbba_pkg::pos_t      start,
    output rbba_pkg::len_t      len
);

    rbba_pkg::pos_t start_reg;
    rbba_pkg::pos_t start_next;
    rbba_pkg::len_t len_reg;
    rbba_pkg::len_t len_next;
    logic           match;
    logic           take_nb;

    // A live entry matches when its start equals the key.
    assign match   = ctl.valid && (start_reg == key);
    assign hit_out = hit_in || match;
    assign take_nb = ctl.shift_en && (hit_in || match);

    // Next entry: a new block, the neighbour's entry, or unchanged.
    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        if (ctl.load)
        begin
            start_next = new_start;
            len_next   = new_len;
        end
        else if (take_nb)
        begin
            start_next = nb_start;
            len_next   = nb_len;
        end
    end

    // Entry storage; contents are meaningful only while the cell is live.
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    assign start = start_reg;
    assign len   = len_reg;

endmodule

### test/rbba_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring buffer block allocator checker
// Watches the register port and both channels of the allocator. Each request
// transfer is run through a local copy of the allocator state to produce the
// expected response. Each response transfer is compared field by field with
// the oldest expected response. The count of failures and the number of
// responses still due are passed to the testbench top.
// ----------------------------------------------------------------------------
module rbba_checker
#(
    parameter int unsigned STORE_BYTES = 4096,
    parameter int unsigned MAX_BLOCKS  = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbba_pkg::APB_AW-1:0]   paddr,
    input  logic [rbba_pkg::APB_DW-1:0]   pwdata,
    input  logic                          pready,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [1:0]                    kind,
    input  logic [rbba_pkg::LEN_W-1:0]    length,
    input  logic [rbba_pkg::OFF_W-1:0]    offset,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [2:0]                    status,
    input  logic [rbba_pkg::OFF_W-1:0]    block_offset,
    input  logic [rbba_pkg::LIVE_W-1:0]   live_blocks,
    output int unsigned                   failures,
    output int unsigned                   awaiting
);

    typedef struct {
        rbba_pkg::status_t                status;
        logic [rbba_pkg::OFF_W-1:0]       where;
        logic [rbba_pkg::LIVE_W-1:0]      live;
    } reply_t;

    // Local copy of the allocator state.
    logic [rbba_pkg::CAP_W-1:0] cap_reg = rbba_pkg::CAP_RESET;
    int unsigned      ring_start = 0;
    int unsigned      ring_end = 0;
    int unsigned      live_count = 0;
    int unsigned      block_at [MAX_BLOCKS];
    int unsigned      block_len [MAX_BLOCKS];

    // Responses still owed by the block, oldest first.
    reply_t replies_due [$];

    initial failures = 0;
    initial awaiting = 0;

    // A new capacity empties the store, as after reset.
    function automatic void empty_store();
        ring_start = 0;
        ring_end = 0;
        live_count = 0;
    endfunction

    // Applies one request to the local state and returns the response it earns.
    function automatic reply_t serve_request(input logic [1:0] op,
                                             input logic [rbba_pkg::LEN_W-1:0] len_in,
                                             input logic [rbba_pkg::OFF_W-1:0] off_in);
        reply_t      r;
        int unsigned cap;
        int unsigned len;
        int unsigned head_room;
        int unsigned after;
        int unsigned pos;
        int unsigned hit;
        int unsigned i;
        logic        fits;
        cap = (cap_reg > STORE_BYTES) ? STORE_BYTES : cap_reg;
        len = len_in;
        pos = 0;
        r.status = rbba_pkg::STAT_NOT_FOUND;
        r.where = '0;
        if (op == rbba_pkg::KIND_TRACKED || op == rbba_pkg::KIND_UNTRACKED)
        begin
            if (cap == 0 || len == 0 || len > cap)
                r.status = rbba_pkg::STAT_BAD_LENGTH;
            else if (op == rbba_pkg::KIND_TRACKED && live_count >= MAX_BLOCKS)
                r.status = rbba_pkg::STAT_LIST_FULL;
            else
            begin
                // Room after the end first, then the gap before the start.
                head_room = 0;
                if (ring_start <= ring_end)
                begin
                    head_room = ring_start;
                    after = (ring_end <= cap) ? cap - ring_end : 0;
                end
                else
                    after = ring_start - ring_end;
                fits = 1'b1;
                if (after >= len)
                    pos = ring_end;
                else if (len <= head_room)
                    pos = 0;
                else
                    fits = 1'b0;
                if (!fits)
                    r.status = rbba_pkg::STAT_NO_ROOM;
                else
                begin
                    r.status = rbba_pkg::STAT_GRANTED;
                    r.where = pos[rbba_pkg::OFF_W-1:0];
                    if (op == rbba_pkg::KIND_UNTRACKED)
                        ring_start = pos;
                    ring_end = pos + len;
                    if (op == rbba_pkg::KIND_TRACKED)
                    begin
                        block_at[live_count] = pos;
                        block_len[live_count] = len;
                        live_count++;
                    end
                end
            end
        end
        else if (op == rbba_pkg::KIND_FREE && cap != 0)
        begin
            // Only the first entry with a matching start is removed.
            hit = live_count;
            for (i = 0; i < live_count; i++)
                if (hit == live_count && block_at[i] == off_in)
                    hit = i;
            if (hit < live_count)
            begin
                for (i = hit; i + 1 < live_count; i++)
                begin
                    block_at[i] = block_at[i + 1];
                    block_len[i] = block_len[i + 1];
                end
                live_count--;
                if (live_count == 0)
                    empty_store();
                else
                begin
                    ring_start = block_at[0];
                    ring_end = block_at[live_count - 1] + block_len[live_count - 1];
                end
                r.status = rbba_pkg::STAT_FREED;
            end
        end
        r.live = live_count[rbba_pkg::LIVE_W-1:0];
        return r;
    endfunction

    // Counts a failure and reports only the first few of them.
    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    // Responses are checked before the request of the same edge is applied,
    // since no response can leave in the cycle its request is taken.
    always @(posedge clk or negedge rst_n)
    begin
        reply_t due;
        if (!rst_n)
        begin
            cap_reg = rbba_pkg::CAP_RESET;
            empty_store();
            replies_due.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                    note_failure($sformatf(
                        "response with none due: status %0d offset %0d live %0d",
                        status, block_offset, live_blocks));
                else
                begin
                    due = replies_due.pop_front();
                    if (status !== due.status || block_offset !== due.where ||
                        live_blocks !== due.live)
                        note_failure($sformatf(
                            "expected status %0d offset %0d live %0d, got %0d %0d %0d",
                            due.status, due.where, due.live,
                            status, block_offset, live_blocks));
                end
            end
            if (psel && penable && pwrite && pready &&
                paddr[2] == rbba_pkg::REG_CAPACITY)
            begin
                cap_reg = pwdata[rbba_pkg::CAP_W-1:0];
                empty_store();
            end
            if (req_valid && !req_stall)
                replies_due.push_back(serve_request(kind, length, offset));
        end
        awaiting = replies_due.size();
    end

endmodule

### test/ring_buffer_block_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring buffer block allocator testbench
// Drives requests and capacity writes into the allocator and lets the
// checker judge every response. A directed sequence covers the corner cases,
// then random traffic runs through several capacities, including zero, one
// and a value above the store size, with random idle cycles on both channels
// and one long hold on the response side that backs the block up.
// ----------------------------------------------------------------------------
module ring_buffer_block_allocator_tb;

    localparam logic [rbba_pkg::APB_AW-1:0] CAPACITY_ADDR = 3'd0;
    localparam int unsigned       HOLD_CYCLES   = 48;
    localparam int unsigned       LEN_MAX       = 8191;
    localparam int unsigned       STORE_SIZE    = 4096;

    // Two more tracked requests than the list can hold.
    localparam int unsigned MAX_BLOCKS_FILL = 18;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rbba_pkg::APB_AW-1:0]   paddr;
    logic [rbba_pkg::APB_DW-1:0]   pwdata;
    logic [rbba_pkg::APB_DW-1:0]   prdata;
    logic                          pready;
    logic                          req_valid;
    logic                          req_stall;
    logic [1:0]                    kind;
    logic [rbba_pkg::LEN_W-1:0]    length;
    logic [rbba_pkg::OFF_W-1:0]    offset;
    logic                          rsp_valid;
    logic                          rsp_stall;
    logic [2:0]                    status;
    logic [rbba_pkg::OFF_W-1:0]    block_offset;
    logic [rbba_pkg::LIVE_W-1:0]   live_blocks;

    int unsigned         failures;
    int unsigned         awaiting;

    // Stimulus controls shared with the response side.
    logic                idle_on = 1'b1;
    int unsigned         hold_asks = 0;
    int unsigned         cap_now = rbba_pkg::CAP_RESET;

    // Offsets handed out so far, used to aim frees at live blocks.
    logic [rbba_pkg::OFF_W-1:0]    granted_offsets [$];

    ring_buffer_block_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .length       (length),
        .offset       (offset),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .block_offset (block_offset),
        .live_blocks  (live_blocks)
    );

    rbba_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .length       (length),
        .offset       (offset),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .block_offset (block_offset),
        .live_blocks  (live_blocks),
        .failures     (failures),
        .awaiting     (awaiting)
    );

    always #6 clk = ~clk;

    // Collect granted offsets from response transfers.
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall && status == rbba_pkg::STAT_GRANTED)
            granted_offsets.push_back(block_offset);
    end

    // Response side: short random stalls, and one long hold when asked.
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_served;
        stall_left = 0;
        hold_served = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asks)
            begin
                hold_served = hold_asks;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left != 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Offers one request, after an optional idle burst, and waits for its
    // transfer. Called and returns at a falling edge.
    task automatic send_request(input logic [1:0] op,
                                input logic [rbba_pkg::LEN_W-1:0] len,
                                input logic [rbba_pkg::OFF_W-1:0] off);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        kind <= op;
        length <= len;
        offset <= off;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Writes the capacity once the block has answered everything.
    task automatic write_capacity(input logic [rbba_pkg::CAP_W-1:0] value);
        req_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAPACITY_ADDR;
        pwdata <= {{(rbba_pkg::APB_DW-rbba_pkg::CAP_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        granted_offsets.delete();
        cap_now = value;
    endtask

    // Lengths scaled to the current capacity, with the odd bad one mixed in.
    function automatic logic [rbba_pkg::LEN_W-1:0] pick_length(input bit modest);
        int unsigned eff;
        int unsigned r;
        eff = (cap_now > STORE_SIZE) ? STORE_SIZE : cap_now;
        r = $urandom_range(0, 99);
        if (eff == 0)
            return rbba_pkg::LEN_W'($urandom_range(0, LEN_MAX));
        if (modest)
            return rbba_pkg::LEN_W'($urandom_range(1, (eff / 24 > 1) ? eff / 24 : 1));
        if (r < 3)
            return '0;
        if (r < 6)
            return rbba_pkg::LEN_W'($urandom_range(eff + 1, LEN_MAX));
        if (r < 8)
            return rbba_pkg::LEN_W'(eff);
        if (r < 10)
            return rbba_pkg::LEN_W'(LEN_MAX);
        if (r < 20)
            return rbba_pkg::LEN_W'($urandom_range(1, eff));
        return rbba_pkg::LEN_W'($urandom_range(1, (eff / 8 > 1) ? eff / 8 : 1));
    endfunction

    // Random traffic: mostly allocate and free of live blocks, with runs that
    // fill the list and runs that release everything handed out.
    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned r;
        int unsigned k;
        int unsigned n;
        int unsigned pick;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 11);
            if (r == 0)
            begin
                for (k = 0; k < MAX_BLOCKS_FILL; k++)
                    send_request(rbba_pkg::KIND_TRACKED, pick_length(1'b1),
                                 rbba_pkg::OFF_W'($urandom()));
                sent += MAX_BLOCKS_FILL;
            end
            else if (r == 1)
            begin
                n = granted_offsets.size();
                for (k = 0; k < n && granted_offsets.size() != 0; k++)
                begin
                    pick = $urandom_range(0, granted_offsets.size() - 1);
                    send_request(rbba_pkg::KIND_FREE, rbba_pkg::LEN_W'($urandom()),
                                 granted_offsets[pick]);
                    granted_offsets.delete(pick);
                end
                sent += (n == 0) ? 1 : n;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_request(rbba_pkg::KIND_TRACKED, pick_length(1'b0),
                                 rbba_pkg::OFF_W'($urandom()));
                else if (r < 55)
                    send_request(rbba_pkg::KIND_UNTRACKED, pick_length(1'b0),
                                 rbba_pkg::OFF_W'($urandom()));
                else if (r < 85 && granted_offsets.size() != 0)
                begin
                    pick = $urandom_range(0, granted_offsets.size() - 1);
                    send_request(rbba_pkg::KIND_FREE, rbba_pkg::LEN_W'($urandom()),
                                 granted_offsets[pick]);
                    granted_offsets.delete(pick);
                end
                else if (r < 93)
                    send_request(rbba_pkg::KIND_FREE, rbba_pkg::LEN_W'($urandom()),
                                 rbba_pkg::OFF_W'($urandom()));
                else
                    send_request(rbba_pkg::KIND_NONE, rbba_pkg::LEN_W'($urandom()),
                                 rbba_pkg::OFF_W'($urandom()));
                sent++;
            end
        end
    endtask

    // Corner cases at the reset capacity of 4096 bytes.
    task automatic run_directed();
        // Bad lengths, an unknown kind and a free on an empty list.
        send_request(rbba_pkg::KIND_TRACKED, 13'd0, 12'd0);
        send_request(rbba_pkg::KIND_TRACKED, 13'd8191, 12'd4095);
        send_request(rbba_pkg::KIND_TRACKED, 13'd4097, 12'd0);
        send_request(rbba_pkg::KIND_NONE, 13'd8191, 12'd4095);
        send_request(rbba_pkg::KIND_FREE, 13'd0, 12'd4095);
        // Fill to the top, then wrap onto a start already in the list.
        send_request(rbba_pkg::KIND_TRACKED, 13'd4000, 12'd0);
        send_request(rbba_pkg::KIND_UNTRACKED, 13'd96, 12'd0);
        send_request(rbba_pkg::KIND_TRACKED, 13'd100, 12'd0);
        // Gap between end and start: one byte too many, then an exact fit.
        send_request(rbba_pkg::KIND_TRACKED, 13'd3901, 12'd0);
        send_request(rbba_pkg::KIND_TRACKED, 13'd3900, 12'd0);
        // Duplicate starts go one at a time, oldest first.
        send_request(rbba_pkg::KIND_FREE, 13'd0, 12'd0);
        send_request(rbba_pkg::KIND_FREE, 13'd0, 12'd0);
        // Untracked wrap, a whole-store request with no room, then empty it.
        send_request(rbba_pkg::KIND_UNTRACKED, 13'd97, 12'd0);
        send_request(rbba_pkg::KIND_TRACKED, 13'd4096, 12'd0);
        send_request(rbba_pkg::KIND_FREE, 13'd0, 12'd100);
        send_request(rbba_pkg::KIND_TRACKED, 13'd4096, 12'd0);
        send_request(rbba_pkg::KIND_TRACKED, 13'd1, 12'd0);
        send_request(rbba_pkg::KIND_FREE, 13'd0, 12'd0);
    endtask

    // Main sequence: reset, corner cases, then a walk through capacities.
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = CAPACITY_ADDR;
        pwdata = '0;
        req_valid = 1'b0;
        kind = rbba_pkg::KIND_NONE;
        length = '0;
        offset = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_random(120);
        write_capacity(13'd0);
        run_random(30);
        write_capacity(13'd1);
        run_random(60);
        write_capacity(13'h1FFF);
        run_random(250);
        write_capacity(13'd16);
        run_random(100);
        // The response side holds off while requests keep coming.
        write_capacity(13'd4095);
        hold_asks++;
        run_random(200);
        write_capacity(rbba_pkg::CAP_W'($urandom_range(17, 4094)));
        run_random(200);
        write_capacity(rbba_pkg::CAP_RESET);
        idle_on = 1'b0;
        run_random(250);

        req_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (failures == 0 && awaiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        #2400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
